// ===== src/sdc_pkg.sv =====
// shared constants, item types and lookup tables of the serial date converter
package sdc_pkg;

  // pipeline depth of the two halves
  localparam int TD_STAGES = 11;
  localparam int FD_STAGES = 4;

  // serial range and the fake leap day of 1900
  localparam int SERIAL_MIN  = -693594;
  localparam int SERIAL_MAX  = 2958465;
  localparam int SERIAL_LEAP = 60;

  // julian day offsets
  localparam int JDN_OFFSET  = 68569 + 2415019;
  localparam int SERIAL_BASE = 2415019 + 32075;

  // constant divisors of the serial to date formula
  localparam int D1 = 146097;
  localparam int D2 = 1461001;

  // reciprocal estimates, low by at most one
  localparam int Q1_SHIFT = 42;
  localparam int Q2_SHIFT = 48;
  localparam logic [24:0] R1 = 25'((64'd1 << Q1_SHIFT) / 64'd146097);
  localparam logic [27:0] R2 = 28'((64'd1 << Q2_SHIFT) / 64'd1461001);

  // exact reciprocals for narrow values
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV7_MUL     = 9363;
  localparam int DIV7_SHIFT   = 16;

  // operation codes
  localparam logic OP_TO_DATE   = 1'b0;
  localparam logic OP_TO_SERIAL = 1'b1;

  // one input item
  typedef struct packed {
    logic        op;
    logic [22:0] serial;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } item_t;

  // item handed from the date half to the serial and weekday half
  typedef struct packed {
    logic        op;
    logic        in_range;
    logic [22:0] serial;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } mid_t;

  // floor(2447 * j / 80)
  function automatic logic [8:0] day_offset(input logic [3:0] j);
    logic [8:0] r;
    case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

  // floor(367 * (m - 2 + 12a) / 12), a set for january and february
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // weekday month offsets, indexed by month minus one
  function automatic logic [2:0] wd_offset(input logic [3:0] idx);
    logic [2:0] r;
    case (idx)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd5;
      4'd4:    r = 3'd0;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd1;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd6;
      4'd10:   r = 3'd2;
      4'd11:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sdc_to_date.sv =====
// serial to gregorian date pipeline, eleven register stages
module sdc_to_date (
  input  logic                            clk,
  input  logic [sdc_pkg::TD_STAGES-1:0]   en,
  input  sdc_pkg::item_t                  item_in,
  output sdc_pkg::mid_t                   mid_out
);

  localparam int NC = sdc_pkg::TD_STAGES - 1;

  // raw item and range flags travelling beside the arithmetic
  sdc_pkg::item_t item_pipe [NC];
  logic [NC-1:0]  rng_pipe;
  logic [NC-1:0]  s60_pipe;

  logic signed [22:0] s;
  logic               s_lt60;
  logic               in_range;
  logic               is60;
  logic [24:0]        l_c;
  logic [49:0]        prod1;
  logic [25:0]        r_c;
  logic               r_ge;
  logic [18:0]        rr;
  logic [55:0]        prod2;
  logic [27:0]        r2_c;
  logic [16:0]        l3_c;
  logic [3:0]         j_c;
  logic [8:0]         off;
  logic [8:0]         dd_c;
  logic               k_c;
  logic [3:0]         mm_c;
  logic [15:0]        yy_c;

  // stage registers
  logic [22:0] l_s1, l_s2;
  logic [7:0]  q0_s2, q0_s3;
  logic [18:0] r_s3;
  logic [7:0]  n_s4, n_s5, n_s6, n_s7, n_s8, n_s9, n_s10;
  logic [15:0] l2_s4, l2_s5, l2_s6, l2_s7, l2_s8;
  logic [27:0] n2_s5, n2_s6;
  logic [6:0]  i0_s6, i0_s7;
  logic [21:0] r2_s7;
  logic [6:0]  i_s8, i_s9, i_s10;
  logic [8:0]  l3_s9, l3_s10;
  logic [3:0]  j_s10;
  sdc_pkg::mid_t mid_q;

  // range check and shift onto the julian day count
  assign s        = item_in.serial;
  assign s_lt60   = s < 23'(sdc_pkg::SERIAL_LEAP);
  assign is60     = s == 23'(sdc_pkg::SERIAL_LEAP);
  assign in_range = (s >= 23'(sdc_pkg::SERIAL_MIN)) && (s <= 23'(sdc_pkg::SERIAL_MAX));
  assign l_c      = {{2{s[22]}}, s} + 25'(s_lt60) + 25'(sdc_pkg::JDN_OFFSET);

  // quadricentennial quotient estimate and remainder
  assign prod1 = 50'({l_s1, 2'b00}) * 50'(sdc_pkg::R1);
  assign r_c   = 26'({l_s2, 2'b00}) - 26'(sdc_pkg::D1) * 26'(q0_s2);
  assign r_ge  = r_s3 >= 19'(sdc_pkg::D1);
  assign rr    = r_ge ? (r_s3 - 19'(sdc_pkg::D1)) : r_s3;

  // year-in-century quotient estimate and remainder
  assign prod2 = 56'(n2_s5) * 56'(sdc_pkg::R2);
  assign r2_c  = n2_s6 - 28'(sdc_pkg::D2) * 28'(i0_s6);

  // day within the march-based year
  assign l3_c = {1'b0, l2_s8} - 17'((18'(i_s8) * 18'd1461) >> 2) + 17'd31;

  // month index by threshold count
  always_comb begin
    j_c = '0;
    for (int t = 1; t < 16; t++) begin
      if (l3_s9 > sdc_pkg::day_offset(4'(t))) j_c = j_c + 4'd1;
    end
  end

  // day, month and year from the month index
  assign off  = sdc_pkg::day_offset(j_s10);
  assign dd_c = l3_s10 - off;
  assign k_c  = j_s10 >= 4'd11;
  assign mm_c = j_s10 + 4'd2 - (k_c ? 4'd12 : 4'd0);
  assign yy_c = 16'(n_s10) * 16'd100 - 16'd4900 + 16'(i_s10) + 16'(k_c);

  // side pipe of the raw item
  always_ff @(posedge clk) begin
    if (en[0]) begin
      item_pipe[0] <= item_in;
      rng_pipe[0]  <= in_range;
      s60_pipe[0]  <= is60;
    end
    for (int k = 1; k < NC; k++) begin
      if (en[k]) begin
        item_pipe[k] <= item_pipe[k-1];
        rng_pipe[k]  <= rng_pipe[k-1];
        s60_pipe[k]  <= s60_pipe[k-1];
      end
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      l_s1 <= l_c[22:0];
    end
    if (en[1]) begin
      q0_s2 <= prod1[sdc_pkg::Q1_SHIFT +: 8];
      l_s2  <= l_s1;
    end
    if (en[2]) begin
      r_s3  <= r_c[18:0];
      q0_s3 <= q0_s2;
    end
    if (en[3]) begin
      n_s4  <= q0_s3 + 8'(r_ge);
      l2_s4 <= rr[17:2];
    end
    if (en[4]) begin
      n2_s5 <= (28'(l2_s4) + 28'd1) * 28'd4000;
      n_s5  <= n_s4;
      l2_s5 <= l2_s4;
    end
    if (en[5]) begin
      i0_s6 <= prod2[sdc_pkg::Q2_SHIFT +: 7];
      n2_s6 <= n2_s5;
      n_s6  <= n_s5;
      l2_s6 <= l2_s5;
    end
    if (en[6]) begin
      r2_s7 <= r2_c[21:0];
      i0_s7 <= i0_s6;
      n_s7  <= n_s6;
      l2_s7 <= l2_s6;
    end
    if (en[7]) begin
      i_s8  <= i0_s7 + 7'(r2_s7 >= 22'(sdc_pkg::D2));
      n_s8  <= n_s7;
      l2_s8 <= l2_s7;
    end
    if (en[8]) begin
      l3_s9 <= l3_c[8:0];
      n_s9  <= n_s8;
      i_s9  <= i_s8;
    end
    if (en[9]) begin
      j_s10  <= j_c;
      l3_s10 <= l3_s9;
      n_s10  <= n_s9;
      i_s10  <= i_s9;
    end
    // date selection: echo for date input, leap-day quirk, else computed
    if (en[10]) begin
      mid_q.op       <= item_pipe[NC-1].op;
      mid_q.in_range <= rng_pipe[NC-1];
      mid_q.serial   <= item_pipe[NC-1].serial;
      if (item_pipe[NC-1].op == sdc_pkg::OP_TO_SERIAL) begin
        mid_q.day   <= item_pipe[NC-1].day;
        mid_q.month <= item_pipe[NC-1].month;
        mid_q.year  <= item_pipe[NC-1].year;
      end else if (s60_pipe[NC-1]) begin
        mid_q.day   <= 5'd29;
        mid_q.month <= 4'd2;
        mid_q.year  <= 14'd1900;
      end else begin
        mid_q.day   <= dd_c[4:0];
        mid_q.month <= mm_c;
        mid_q.year  <= yy_c[13:0];
      end
    end
  end

  assign mid_out = mid_q;

endmodule

// ===== src/sdc_from_date.sv =====
// date to serial, date check and weekday pipeline, four register stages
module sdc_from_date (
  input  logic                            clk,
  input  logic [sdc_pkg::FD_STAGES-1:0]   en,
  input  sdc_pkg::mid_t                   mid_in,
  output logic [4:0]                      day_out,
  output logic [3:0]                      month_out,
  output logic [13:0]                     year_out,
  output logic [22:0]                     serial_out,
  output logic [2:0]                      weekday,
  output logic                            valid_res
);

  logic        lt3;
  logic [13:0] ay_c;
  logic [26:0] pa_c;
  logic [14:0] a_c;
  logic [24:0] pj_c;
  logic [14:0] b_c;
  logic [26:0] pb_c;
  logic [26:0] py_c;
  logic        rng_c;
  logic        feb29_c;
  logic        febbig_c;
  logic        bad31_c;

  logic [14:0] v_c;
  logic [24:0] sum_c;
  logic        y100;
  logic        leap;
  logic        date_ok;

  logic [27:0] pv_c;
  logic [22:0] sadj_c;
  logic [13:0] wd_c;

  // stage registers
  sdc_pkg::mid_t mid_b1, mid_b2, mid_b3;
  logic [13:0]   ay_b1;
  logic [7:0]    qa_b1;
  logic [2:0]    tw_b1;
  logic [22:0]   t1_b1;
  logic [7:0]    cy_b1;
  logic [8:0]    mterm_b1;
  logic [7:0]    yq_b1;
  logic          basic_b1;
  logic          feb29_b1;
  logic [13:0]   v_b2, v_b3;
  logic signed [24:0] sum_b2;
  logic          valid_b2, valid_b3;
  logic [11:0]   qv_b3;
  logic [22:0]   sadj_b3;

  // first stage: year adjust and constant products
  assign lt3  = mid_in.month < 4'd3;
  assign ay_c = (mid_in.year == 14'd0 && lt3) ? 14'd0 : (mid_in.year - 14'(lt3));
  assign pa_c = 27'(ay_c) * 27'(sdc_pkg::DIV100_MUL);
  assign a_c  = 15'(mid_in.year) + 15'd4800 - 15'(lt3);
  assign pj_c = 25'(a_c) * 25'd1461;
  assign b_c  = 15'(mid_in.year) + 15'd4900 - 15'(lt3);
  assign pb_c = 27'(b_c) * 27'(sdc_pkg::DIV100_MUL);
  assign py_c = 27'(mid_in.year) * 27'(sdc_pkg::DIV100_MUL);

  // plain range checks of the date
  assign rng_c    = (mid_in.day != 5'd0) && (mid_in.month >= 4'd1) &&
                    (mid_in.month <= 4'd12) && (mid_in.year >= 14'd1) &&
                    (mid_in.year <= 14'd9999);
  assign feb29_c  = (mid_in.month == 4'd2) && (mid_in.day == 5'd29);
  assign febbig_c = (mid_in.month == 4'd2) && (mid_in.day > 5'd29);
  assign bad31_c  = (mid_in.day == 5'd31) &&
                    ((mid_in.month == 4'd4) || (mid_in.month == 4'd6) ||
                     (mid_in.month == 4'd9) || (mid_in.month == 4'd11));

  // second stage: weekday sum, serial sum and leap year rule
  assign v_c = 15'(ay_b1) + 15'(ay_b1 >> 2) - 15'(qa_b1) + 15'(qa_b1 >> 2) +
               15'(tw_b1) + 15'(mid_b1.day);
  assign sum_c = 25'(t1_b1) + 25'(mterm_b1) - 25'((10'(cy_b1) * 10'd3) >> 2) +
                 25'(mid_b1.day) - 25'(sdc_pkg::SERIAL_BASE);
  assign y100    = 15'(mid_b1.year) == (15'(yq_b1) * 15'd100);
  assign leap    = ((mid_b1.year[1:0] == 2'd0) && !y100) || (y100 && (yq_b1[1:0] == 2'd0));
  assign date_ok = basic_b1 && (!feb29_b1 || leap);

  // third stage: divide by seven, leap-day shift of low serials
  assign pv_c   = 28'(v_b2) * 28'(sdc_pkg::DIV7_MUL);
  assign sadj_c = (sum_b2 <= 25'(sdc_pkg::SERIAL_LEAP)) ? 23'(sum_b2 - 25'sd1) : sum_b2[22:0];

  // fourth stage: remainder by seven
  assign wd_c = v_b3 - 14'(15'(qv_b3) * 15'd7);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mid_b1   <= mid_in;
      ay_b1    <= ay_c;
      qa_b1    <= pa_c[sdc_pkg::DIV100_SHIFT +: 8];
      tw_b1    <= sdc_pkg::wd_offset(mid_in.month - 4'd1);
      t1_b1    <= pj_c[24:2];
      cy_b1    <= pb_c[sdc_pkg::DIV100_SHIFT +: 8];
      mterm_b1 <= sdc_pkg::month_term(mid_in.month);
      yq_b1    <= py_c[sdc_pkg::DIV100_SHIFT +: 8];
      basic_b1 <= rng_c && !febbig_c && !bad31_c;
      feb29_b1 <= feb29_c;
    end
    if (en[1]) begin
      mid_b2   <= mid_b1;
      v_b2     <= v_c[13:0];
      sum_b2   <= sum_c;
      valid_b2 <= (mid_b1.op == sdc_pkg::OP_TO_SERIAL) ? date_ok : mid_b1.in_range;
    end
    if (en[2]) begin
      mid_b3   <= mid_b2;
      v_b3     <= v_b2;
      qv_b3    <= pv_c[sdc_pkg::DIV7_SHIFT +: 12];
      sadj_b3  <= sadj_c;
      valid_b3 <= valid_b2;
    end
    // output register with masking of rejected items
    if (en[3]) begin
      if (mid_b3.op == sdc_pkg::OP_TO_SERIAL || valid_b3) begin
        day_out   <= mid_b3.day;
        month_out <= mid_b3.month;
        year_out  <= mid_b3.year;
      end else begin
        day_out   <= '0;
        month_out <= '0;
        year_out  <= '0;
      end
      if (mid_b3.op == sdc_pkg::OP_TO_SERIAL) begin
        serial_out <= valid_b3 ? sadj_b3 : '0;
      end else begin
        serial_out <= mid_b3.serial;
      end
      weekday   <= valid_b3 ? wd_c[2:0] : 3'd0;
      valid_res <= valid_b3;
    end
  end

endmodule

// ===== src/serial_date_converter_top.sv =====
// each stage holds one item with its own valid bit; the pipeline takes one item per cycle
// while m_tready is high or some stage from the input to the output is empty
// the stages are set by the chain of constant divisions, each a reciprocal product
// and a remainder correction in its own stages, then the weekday and serial stages
// a stage takes a new item whenever any stage from it to the output is empty
// reset clears the stage valid bits only; the pipeline is empty afterwards
module serial_date_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // serial_in[22:0], day_in[27:23], month_in[31:28], year_in[45:32]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // day_out[4:0], month_out[8:5], year_out[22:9], serial_out[45:23],
                                 // weekday[48:46]
  output logic        m_tuser    // valid_res
);

  localparam int NS = sdc_pkg::TD_STAGES + sdc_pkg::FD_STAGES;

  logic [NS-1:0]  vld;
  logic [NS-1:0]  en;
  sdc_pkg::item_t item_in;
  sdc_pkg::mid_t  mid;
  logic [4:0]     day_out;
  logic [3:0]     month_out;
  logic [13:0]    year_out;
  logic [22:0]    serial_out;
  logic [2:0]     weekday;
  logic           valid_res;

  // a stage advances when m_tready is high or some stage from it to the output is free
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = m_tready || ((vld | ((NS'(1) << k) - NS'(1))) != {NS{1'b1}});
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NS-1];

  // input unpacking
  assign item_in.op     = s_tuser;
  assign item_in.serial = s_tdata[22:0];
  assign item_in.day    = s_tdata[27:23];
  assign item_in.month  = s_tdata[31:28];
  assign item_in.year   = s_tdata[45:32];

  sdc_to_date u_to_date (
    .clk     (clk),
    .en      (en[sdc_pkg::TD_STAGES-1:0]),
    .item_in (item_in),
    .mid_out (mid)
  );

  sdc_from_date u_from_date (
    .clk        (clk),
    .en         (en[NS-1:sdc_pkg::TD_STAGES]),
    .mid_in     (mid),
    .day_out    (day_out),
    .month_out  (month_out),
    .year_out   (year_out),
    .serial_out (serial_out),
    .weekday    (weekday),
    .valid_res  (valid_res)
  );

  // output packing
  assign m_tdata = {7'd0, weekday, serial_out, year_out, month_out, day_out};
  assign m_tuser = valid_res;

endmodule
